// ===== rtl/sh2npc_pkg.sv =====
package sh2npc_pkg;

	localparam logic [15:0] OP_HI8_MASK  = 16'hFF00;
	localparam logic [15:0] OP_HI4_MASK  = 16'hF000;
	localparam logic [15:0] OP_REG_MASK  = 16'hF0FF;

	localparam logic [15:0] OP_BT        = 16'h8900;
	localparam logic [15:0] OP_BTS       = 16'h8D00;
	localparam logic [15:0] OP_BF        = 16'h8B00;
	localparam logic [15:0] OP_BFS       = 16'h8F00;
	localparam logic [15:0] OP_BRA       = 16'hA000;
	localparam logic [15:0] OP_BSR       = 16'hB000;
	localparam logic [15:0] OP_BRAF      = 16'h0023;
	localparam logic [15:0] OP_BSRF      = 16'h0003;
	localparam logic [15:0] OP_JMP       = 16'h402B;
	localparam logic [15:0] OP_JSR       = 16'h400B;
	localparam logic [15:0] OP_RTS       = 16'h000B;
	localparam logic [15:0] OP_RTE       = 16'h002B;
	localparam logic [15:0] OP_TRAPA     = 16'hC300;

	typedef enum logic [3:0] {
		KIND_SEQ     = 4'd0,
		KIND_COND_T  = 4'd1,
		KIND_COND_NT = 4'd2,
		KIND_REL     = 4'd3,
		KIND_REG_REL = 4'd4,
		KIND_REG_ABS = 4'd5,
		KIND_RTS     = 4'd6,
		KIND_RTE     = 4'd7,
		KIND_TRAP    = 4'd8
	} flow_kind_t;

	typedef struct packed {
		logic [15:0] instruction;
		logic [31:0] current_pc;
		logic        t_flag;
		logic [31:0] reg_m_value;
		logic [31:0] link_register;
		logic [31:0] stack_word;
		logic [31:0] vector_base;
		logic [31:0] vector_word;
	} item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		flow_kind_t  kind;
		logic [31:0] vector_address;
	} result_t;

endpackage

// ===== rtl/sh2npc_decode.sv =====
module sh2npc_decode import sh2npc_pkg::*; (
	input  item_t   item,
	output result_t res
);

	logic [15:0] hi8;
	logic [15:0] hi4;
	logic [15:0] regform;
	logic        is_bt;
	logic        is_bf;
	logic        is_rel;
	logic        is_reg_rel;
	logic        taken;
	logic [31:0] disp8;
	logic [31:0] disp12;
	logic [31:0] operand;
	logic [31:0] target;
	logic [31:0] seq_pc;
	logic [31:0] trap_vec;

	assign hi8     = item.instruction & OP_HI8_MASK;
	assign hi4     = item.instruction & OP_HI4_MASK;
	assign regform = item.instruction & OP_REG_MASK;

	assign is_bt      = (hi8 == OP_BT) || (hi8 == OP_BTS);
	assign is_bf      = (hi8 == OP_BF) || (hi8 == OP_BFS);
	assign is_rel     = (hi4 == OP_BRA) || (hi4 == OP_BSR);
	assign is_reg_rel = (regform == OP_BRAF) || (regform == OP_BSRF);
	assign taken      = is_bt ? item.t_flag : !item.t_flag;

	// displacements already doubled
	assign disp8  = {{23{item.instruction[7]}}, item.instruction[7:0], 1'b0};
	assign disp12 = {{19{item.instruction[11]}}, item.instruction[11:0], 1'b0};

	// one shared adder for every pc + x + 4 target
	always_comb begin
		if (is_bt || is_bf) begin
			operand = disp8;
		end else if (is_rel) begin
			operand = disp12;
		end else begin
			operand = item.reg_m_value;
		end
	end

	assign target   = item.current_pc + operand + 32'd4;
	assign seq_pc   = item.current_pc + 32'd2;
	assign trap_vec = item.vector_base + {22'd0, item.instruction[7:0], 2'b00};

	always_comb begin
		res.next_pc        = seq_pc;
		res.kind           = KIND_SEQ;
		res.vector_address = 32'd0;
		if (is_bt || is_bf) begin
			if (taken) begin
				res.next_pc = target;
				res.kind    = KIND_COND_T;
			end else begin
				res.kind    = KIND_COND_NT;
			end
		end else if (is_rel) begin
			res.next_pc = target;
			res.kind    = KIND_REL;
		end else if (is_reg_rel) begin
			res.next_pc = target;
			res.kind    = KIND_REG_REL;
		end else if ((regform == OP_JMP) || (regform == OP_JSR)) begin
			res.next_pc = item.reg_m_value;
			res.kind    = KIND_REG_ABS;
		end else if (item.instruction == OP_RTS) begin
			res.next_pc = item.link_register;
			res.kind    = KIND_RTS;
		end else if (item.instruction == OP_RTE) begin
			res.next_pc = item.stack_word;
			res.kind    = KIND_RTE;
		end else if (hi8 == OP_TRAPA) begin
			res.next_pc        = item.vector_word;
			res.kind           = KIND_TRAP;
			res.vector_address = trap_vec;
		end
	end

endmodule

// ===== rtl/sh2_next_pc_predictor.sv =====
// Next-PC predictor for a single-step debug unit.
// Input channel (in_valid / in_stall) carries one word per instruction: the
// opcode, its PC, the T flag and the register values it may branch through.
// Output channel (out_valid / out_stall) returns one word per input word:
// the predicted next PC, the flow kind and, for TRAPA, the vector address.
// A word accepted into the input register is decoded into the result
// register, which drives the output (two registers: input stage, result
// stage). Throughput: one word per cycle while the output is not stalled;
// decode and its 32-bit adders sit between the two registers.
// When the receiver stalls, the result register holds its word and the
// input register still fills, so one more word is taken before in_stall
// rises; in_stall is only high while both registers are full and the
// output is stalled.
// Reset (arst_n low) empties both stages; the data registers are not reset.
module sh2_next_pc_predictor import sh2npc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] instruction,
	input  logic [31:0] current_pc,
	input  logic        t_flag,
	input  logic [31:0] reg_m_value,
	input  logic [31:0] link_register,
	input  logic [31:0] stack_word,
	input  logic [31:0] vector_base,
	input  logic [31:0] vector_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic [3:0]  flow_kind,
	output logic [31:0] vector_address
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_comb;
	logic    s2_free;
	logic    s1_free;

	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			item_s1.instruction   <= instruction;
			item_s1.current_pc    <= current_pc;
			item_s1.t_flag        <= t_flag;
			item_s1.reg_m_value   <= reg_m_value;
			item_s1.link_register <= link_register;
			item_s1.stack_word    <= stack_word;
			item_s1.vector_base   <= vector_base;
			item_s1.vector_word   <= vector_word;
		end
	end

	sh2npc_decode u_decode (
		.item (item_s1),
		.res  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid      = valid_s2;
	assign next_pc        = res_s2.next_pc;
	assign flow_kind      = res_s2.kind;
	assign vector_address = res_s2.vector_address;

	// vector address only reported for traps
	a_vaddr_trap_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (flow_kind != KIND_TRAP) |-> vector_address == 32'd0)
		else $error("vector_address nonzero outside trap");

	// back-pressure only when both stages hold a word
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in pipeline");

	// a word in stage one moves to the output when the output is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s2_free |=> out_valid)
		else $error("stage one word lost");

endmodule
